### src/stty_pkg.sv
// Package for the serial terminal receive-FIFO device.
// Holds the item structs, the operation, offset, command and result codes,
// and the FIFO sizing constants. Depends on nothing.
package stty_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int IDX_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    localparam logic [11:0] OFS_PUT_CHAR    = 12'h000;
    localparam logic [11:0] OFS_BYTES_READY = 12'h004;
    localparam logic [11:0] OFS_CMD         = 12'h008;
    localparam logic [11:0] OFS_ADDR_LOW    = 12'h010;
    localparam logic [11:0] OFS_LENGTH      = 12'h014;
    localparam logic [11:0] OFS_ADDR_HIGH   = 12'h018;

    localparam logic [31:0] CMD_INT_DISABLE = 32'd0;
    localparam logic [31:0] CMD_INT_ENABLE  = 32'd1;
    localparam logic [31:0] CMD_WRITE_BUF   = 32'd2;
    localparam logic [31:0] CMD_READ_BUF    = 32'd3;

    localparam logic [1:0] KIND_STATUS   = 2'd0;
    localparam logic [1:0] KIND_TX_BYTE  = 2'd1;
    localparam logic [1:0] KIND_MEM_BYTE = 2'd2;
    localparam logic [1:0] KIND_XFER_REQ = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] address;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] read_data;
        logic [7:0]  byte_value;
        logic [63:0] mem_address;
        logic [31:0] transfer_length;
        logic        irq_level;
        logic [5:0]  bytes_free;
        logic        overflow;
        logic        last;
    } t_out_item;

endpackage

### src/stty_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and updates only when a read is enabled.
// Depends on nothing.
module stty_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/serial_tty_rx_fifo_dma_device.sv
// Memory-mapped serial terminal with a receive FIFO and memory transfers.
// Depends on stty_pkg and stty_ram.
//
// Usage: each input item is a bus read, a bus write or one byte from the
// serial backend; it is accepted when i_in_valid and o_in_ready are high.
// Every item produces zero or more side results (an outgoing byte, memory
// byte writes, or a memory-to-serial transfer request) followed by exactly
// one status item with last set, on the o_out_valid/i_out_ready channel.
// The backend_connected register is written through i_cfg_valid/i_cfg_data;
// o_cfg_ready is always high.
//
// Sequencing: one item is handled at a time. A plain item goes from
// S_IDLE to S_STATUS, an item with a side result through S_SIDE first, and
// a drain alternates S_DRAIN_RD (a memory read) and S_DRAIN_WR (an output)
// per byte before S_STATUS. The next item is taken the cycle after the status
// item is loaded. Reset clears the indices, fill count, interrupt enable and
// transfer registers and sets backend_connected; the FIFO memory is not
// cleared, as only entries written by a receive are ever read. When
// i_out_ready is low, the output register keeps its item and states that load
// it wait; o_in_ready depends only on S_IDLE, not on i_out_ready.
module serial_tty_rx_fifo_dma_device (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  stty_pkg::t_in_item i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output stty_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import stty_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SIDE     = 3'd1;
    localparam logic [2:0] S_DRAIN_RD = 3'd2;
    localparam logic [2:0] S_DRAIN_WR = 3'd3;
    localparam logic [2:0] S_STATUS   = 3'd4;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
    localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(FIFO_DEPTH);

    // Control state
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic              r_connected;
    logic [IDX_W-1:0]  r_ridx;
    logic [IDX_W-1:0]  r_widx;
    logic [FILL_W-1:0] r_fill;
    logic              r_irq_en;
    logic [63:0]       r_buf_addr;
    logic [31:0]       r_buf_len;
    logic              r_out_valid;

    // Item held while it is worked on
    logic [11:0]       r_addr;
    logic [31:0]       r_wd;
    logic [1:0]        r_op;
    logic              r_ovf;
    logic [31:0]       r_cnt;
    t_out_item         r_out;
    t_out_item         n_out;
    logic              n_load;

    logic              w_in_acc;
    logic              w_slot_free;
    logic              w_full;
    logic              w_side;
    logic              w_drain;
    logic              w_more;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [7:0]        w_ram_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_full      = (r_fill == DEPTH_F);

    // An outgoing byte or a transfer request comes before the status item.
    assign w_side = (i_in.operation == OP_WRITE) && r_connected &&
                    ((i_in.address == OFS_PUT_CHAR) ||
                     ((i_in.address == OFS_CMD) && (i_in.write_data == CMD_WRITE_BUF) &&
                      (r_buf_len != 32'd0)));
    assign w_drain = (i_in.operation == OP_WRITE) && (i_in.address == OFS_CMD) &&
                     (i_in.write_data == CMD_READ_BUF);

    // Drain continues while length remains and the FIFO holds bytes.
    assign w_more   = (r_cnt < r_buf_len) && (r_fill != '0);
    assign w_ram_we = w_in_acc && (i_in.operation == OP_RX) && !w_full;
    assign w_ram_re = (r_state == S_DRAIN_RD) && w_more;

    stty_ram #(
        .DEPTH(FIFO_DEPTH),
        .WIDTH(8)
    ) u_fifo_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_widx),
        .i_wdata(i_in.rx_byte),
        .i_re   (w_ram_re),
        .i_raddr(r_ridx),
        .o_rdata(w_ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_load  = 1'b0;
        n_out   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_side) begin
                        n_state = S_SIDE;
                    end else if (w_drain) begin
                        n_state = S_DRAIN_RD;
                    end else begin
                        n_state = S_STATUS;
                    end
                end
            end
            S_SIDE: begin
                if (w_slot_free) begin
                    n_load = 1'b1;
                    if (r_addr == OFS_PUT_CHAR) begin
                        n_out.kind       = KIND_TX_BYTE;
                        n_out.byte_value = r_wd[7:0];
                    end else begin
                        n_out.kind            = KIND_XFER_REQ;
                        n_out.mem_address     = r_buf_addr;
                        n_out.transfer_length = r_buf_len;
                    end
                    n_state = S_STATUS;
                end
            end
            S_DRAIN_RD: begin
                n_state = w_more ? S_DRAIN_WR : S_STATUS;
            end
            S_DRAIN_WR: begin
                if (w_slot_free) begin
                    n_load            = 1'b1;
                    n_out.kind        = KIND_MEM_BYTE;
                    n_out.byte_value  = w_ram_rdata;
                    n_out.mem_address = r_buf_addr + {32'd0, r_cnt};
                    n_state           = S_DRAIN_RD;
                end
            end
            S_STATUS: begin
                if (w_slot_free) begin
                    n_load = 1'b1;
                    n_out.kind = KIND_STATUS;
                    if ((r_op == OP_READ) && (r_addr == OFS_BYTES_READY)) begin
                        n_out.read_data = 32'(r_fill);
                    end
                    n_out.irq_level  = r_irq_en && (r_fill != '0);
                    n_out.bytes_free = 6'(DEPTH_F - r_fill);
                    n_out.overflow   = r_ovf;
                    n_out.last       = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_connected <= 1'b1;
            r_ridx      <= '0;
            r_widx      <= '0;
            r_fill      <= '0;
            r_irq_en    <= 1'b0;
            r_buf_addr  <= '0;
            r_buf_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_load || (r_out_valid && !i_out_ready);
            if (i_cfg_valid) begin
                r_connected <= i_cfg_data;
            end
            if (w_in_acc && (i_in.operation == OP_WRITE)) begin
                case (i_in.address)
                    OFS_ADDR_LOW:  r_buf_addr[31:0]  <= i_in.write_data;
                    OFS_ADDR_HIGH: r_buf_addr[63:32] <= i_in.write_data;
                    OFS_LENGTH:    r_buf_len         <= i_in.write_data;
                    OFS_CMD: begin
                        if (i_in.write_data == CMD_INT_DISABLE) begin
                            r_irq_en <= 1'b0;
                        end else if (i_in.write_data == CMD_INT_ENABLE) begin
                            r_irq_en <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (w_ram_we) begin
                r_widx <= (r_widx == LAST_IDX) ? '0 : r_widx + 1'b1;
                r_fill <= r_fill + 1'b1;
            end
            if (w_ram_re) begin
                r_ridx <= (r_ridx == LAST_IDX) ? '0 : r_ridx + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= i_in.operation;
            r_addr <= i_in.address;
            r_wd   <= i_in.write_data;
            r_ovf  <= (i_in.operation == OP_RX) && w_full;
            r_cnt  <= '0;
        end else if ((r_state == S_DRAIN_WR) && w_slot_free) begin
            r_cnt <= r_cnt + 32'd1;
        end
        if (n_load) begin
            r_out <= n_out;
        end
    end

endmodule
